>>> rtl/rgb_window_mean_median_filter_unit_defines.svh
// Assertion macros shared by the filter RTL.
`ifndef RGB_WINDOW_MEAN_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define RGB_WINDOW_MEAN_MEDIAN_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RWMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define RWMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rwmf_pkg.sv
// Shared constants and control structs of the RGB window filter.
package rwmf_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned RING_ROWS  = 8;
  localparam int unsigned MAX_CELLS  = 49;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned RING_W     = 3;
  localparam int unsigned ADDR_W     = RING_W + COL_W;
  localparam int unsigned PIX_W      = 24;
  localparam int unsigned CNT_W      = 6;

  // Config register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WINDOW = 3'd2;
  localparam logic [2:0] REG_MODE   = 3'd3;

  typedef struct packed {
    logic clr;
    logic cap;
    logic go;
    logic mean;
  } ctl_t;

  typedef struct packed {
    logic       done;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } stat_t;

endpackage

>>> rtl/rwmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rwmf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/rwmf_calc.sv
// Window cell store with shared radix-select median and restoring divider lanes.
module rwmf_calc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rwmf_pkg::ctl_t       ctl_i,
  input  logic [23:0]          cap_data_i,
  output rwmf_pkg::stat_t      stat_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SEL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [5:0]  cnt_q;
  logic [13:0] sum_q [3];
  logic [1:0]  ph_q;
  logic        mean_q;
  logic [2:0]  bit_q;
  logic [5:0]  idx_q;
  logic [3:0]  iter_q;
  logic [7:0]  pa_q [3];
  logic [7:0]  pb_q [3];
  logic [5:0]  ka_q [3];
  logic [5:0]  kb_q [3];
  logic [5:0]  ca_q [3];
  logic [5:0]  cb_q [3];
  logic [6:0]  rem_q [3];
  logic [13:0] num_q [3];

  logic [23:0] cur;
  logic [5:0]  rd_idx;
  logic        cell_we;
  logic [7:0]  v [3];
  logic        ma [3];
  logic        mb [3];
  logic [5:0]  na [3];
  logic [5:0]  nb [3];
  logic [6:0]  sh [3];
  logic        ge [3];
  logic [8:0]  med [3];
  logic [7:0]  res [3];
  logic        last;
  logic [3:0]  shamt;

  assign cell_we = ctl_i.cap && !ctl_i.clr;

  // cell store; read address runs one step ahead so cur matches idx_q
  rwmf_ram #(
    .WIDTH (rwmf_pkg::PIX_W),
    .DEPTH (rwmf_pkg::MAX_CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cnt_q),
    .wdata_i (cap_data_i),
    .raddr_i (rd_idx),
    .rdata_o (cur)
  );

  always_comb begin
    last  = (idx_q == cnt_q - 6'd1);
    shamt = {1'b0, bit_q} + 4'd1;
    rd_idx = idx_q;
    if (!ctl_i.clr && !ctl_i.cap) begin
      if (ctl_i.go) begin
        rd_idx = '0;
      end else if (ph_q == PH_SEL) begin
        rd_idx = last ? 6'd0 : idx_q + 6'd1;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      v[ch]   = cur[ch*8 +: 8];
      // candidate keeps the prefix above the current bit and has a zero there
      ma[ch]  = (((v[ch] ^ pa_q[ch]) >> shamt) == 8'd0) && !v[ch][bit_q];
      mb[ch]  = (((v[ch] ^ pb_q[ch]) >> shamt) == 8'd0) && !v[ch][bit_q];
      na[ch]  = ca_q[ch] + {5'd0, ma[ch]};
      nb[ch]  = cb_q[ch] + {5'd0, mb[ch]};
      sh[ch]  = {rem_q[ch][5:0], num_q[ch][13]};
      ge[ch]  = (sh[ch] >= {1'b0, cnt_q});
      med[ch] = {1'b0, pa_q[ch]} + {1'b0, pb_q[ch]};
      res[ch] = mean_q ? num_q[ch][7:0] : med[ch][8:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      cnt_q <= '0;
    end else begin
      if (ctl_i.clr) begin
        ph_q  <= PH_IDLE;
        cnt_q <= '0;
        for (int ch = 0; ch < 3; ch++) sum_q[ch] <= '0;
      end else if (ctl_i.cap) begin
        cnt_q <= cnt_q + 6'd1;
        for (int ch = 0; ch < 3; ch++) begin
          sum_q[ch] <= sum_q[ch] + {6'd0, cap_data_i[ch*8 +: 8]};
        end
      end else if (ctl_i.go) begin
        mean_q <= ctl_i.mean;
        bit_q  <= 3'd7;
        idx_q  <= '0;
        iter_q <= '0;
        for (int ch = 0; ch < 3; ch++) begin
          pa_q[ch]  <= '0;
          pb_q[ch]  <= '0;
          ka_q[ch]  <= (cnt_q - 6'd1) >> 1;
          kb_q[ch]  <= cnt_q >> 1;
          ca_q[ch]  <= '0;
          cb_q[ch]  <= '0;
          rem_q[ch] <= '0;
          num_q[ch] <= sum_q[ch];
        end
        ph_q <= ctl_i.mean ? PH_DIV : PH_SEL;
      end else begin
        unique case (ph_q)
          PH_SEL: begin
            for (int ch = 0; ch < 3; ch++) begin
              if (last) begin
                ca_q[ch] <= '0;
                cb_q[ch] <= '0;
                if (ka_q[ch] >= na[ch]) begin
                  pa_q[ch][bit_q] <= 1'b1;
                  ka_q[ch]        <= ka_q[ch] - na[ch];
                end
                if (kb_q[ch] >= nb[ch]) begin
                  pb_q[ch][bit_q] <= 1'b1;
                  kb_q[ch]        <= kb_q[ch] - nb[ch];
                end
              end else begin
                ca_q[ch] <= na[ch];
                cb_q[ch] <= nb[ch];
              end
            end
            if (last) begin
              idx_q <= '0;
              if (bit_q == 3'd0) begin
                ph_q <= PH_DONE;
              end else begin
                bit_q <= bit_q - 3'd1;
              end
            end else begin
              idx_q <= idx_q + 6'd1;
            end
          end
          PH_DIV: begin
            for (int ch = 0; ch < 3; ch++) begin
              rem_q[ch] <= ge[ch] ? (sh[ch] - {1'b0, cnt_q}) : sh[ch];
              num_q[ch] <= {num_q[ch][12:0], ge[ch]};
            end
            iter_q <= iter_q + 4'd1;
            if (iter_q == 4'd13) begin
              ph_q <= PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign stat_o.done  = (ph_q == PH_DONE);
  assign stat_o.red   = res[0];
  assign stat_o.green = res[1];
  assign stat_o.blue  = res[2];

`include "rgb_window_mean_median_filter_unit_defines.svh"

  `RWMF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= 6'd49, "cell count above window size")
  `RWMF_ASSERT_NEXT(a_go_leaves_idle, ctl_i.go && !ctl_i.clr && !ctl_i.cap,
    ph_q == PH_SEL || ph_q == PH_DIV, "start did not launch a pass")
  `RWMF_ASSERT_NOW(a_sel_index, ph_q == PH_SEL, idx_q < cnt_q, "select index past count")

endmodule

>>> rtl/rgb_window_mean_median_filter_unit.sv
// Top level of the RGB window mean/median filter.
//
// Input words arrive on s_axis in raster order: tdata holds red, green, blue
// (bits 7:0, 15:8, 23:16), tuser is 1 for a drain word without pixel data.
// Each word yields at most one output word on m_axis: the filtered pixel at
// the oldest position whose clipped window has fully arrived. tlast marks the
// last pixel of the frame. Drain words push out the delayed tail rows.
// Pixels go into an 8-row line store RAM; per output the window is gathered
// from it one cell at a time, read in S_RD and captured in S_CAP (up to 49
// cells), then one shared selection unit finds the median by radix select (8
// passes over the cells) or a restoring divider forms the mean. A word
// without output goes through S_CHECK straight back to idle.
// s_axis_tready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next word is taken while it waits.
// A stalled receiver holds the block only when a second result is ready.
// Reset (async, active low) restores the default registers and clears all
// position counters; line store contents stay undefined until written.
// Config writes (cfg_ready_o always high) restart the frame; index 0 width,
// 1 height, 2 window size, 3 mode; other indexes are ignored.
module rgb_window_mean_median_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_red, out_green, out_blue
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CAP   = 3'd3;
  localparam logic [2:0] S_GO    = 3'd4;
  localparam logic [2:0] S_CALC  = 3'd5;

  logic [10:0] width_q, height_q;
  logic [2:0]  wsize_q;
  logic        mode_q;

  logic [2:0]  state_q, state_d;
  logic [9:0]  in_col_q, in_col_d, in_row_q, in_row_d;
  logic [9:0]  out_col_q, out_col_d, out_row_q, out_row_d;
  logic        in_done_q, in_done_d;
  logic [9:0]  r_q, r_d, c_q, c_d;
  logic [9:0]  r0_q, r0_d, c0_q, c0_d, r1_q, r1_d, c1_q, c1_d;
  logic        out_valid_q, out_valid_d;
  logic [23:0] out_data_q, out_data_d;
  logic        out_last_q, out_last_d;

  logic [10:0] w_eff, h_eff;
  logic [1:0]  nm;
  logic [10:0] r1_c, c1_c, rsum, csum;
  logic        win_ready;
  logic        in_acc, cfg_acc, pix_we, out_fire;
  logic [23:0] ram_rdata;
  logic [12:0] waddr, raddr;

  rwmf_pkg::ctl_t  ctl;
  rwmf_pkg::stat_t stat;

  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pix_we        = in_acc && !s_axis_tuser && !in_done_q;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  always_comb begin
    if (width_q == 11'd0) w_eff = 11'd1;
    else if (width_q > 11'(rwmf_pkg::MAX_WIDTH)) w_eff = 11'(rwmf_pkg::MAX_WIDTH);
    else w_eff = width_q;
    if (height_q == 11'd0) h_eff = 11'd1;
    else if (height_q > 11'(rwmf_pkg::MAX_HEIGHT)) h_eff = 11'(rwmf_pkg::MAX_HEIGHT);
    else h_eff = height_q;
    nm = wsize_q[2:1];
    rsum = {1'b0, out_row_q} + {9'd0, nm};
    csum = {1'b0, out_col_q} + {9'd0, nm};
    r1_c = (rsum > h_eff - 11'd1) ? h_eff - 11'd1 : rsum;
    c1_c = (csum > w_eff - 11'd1) ? w_eff - 11'd1 : csum;
    // window complete once its bottom-right pixel lies before the write point
    win_ready = in_done_q || (r1_c < {1'b0, in_row_q})
             || ((r1_c == {1'b0, in_row_q}) && (c1_c < {1'b0, in_col_q}));
  end

  assign waddr = {in_row_q[2:0], in_col_q};
  assign raddr = {r_q[2:0], c_q};

  rwmf_ram #(
    .WIDTH (rwmf_pkg::PIX_W),
    .DEPTH (rwmf_pkg::RING_ROWS * rwmf_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  rwmf_calc u_calc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .cap_data_i (ram_rdata),
    .stat_o     (stat)
  );

  always_comb begin
    state_d     = state_q;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    in_done_d   = in_done_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    r_d = r_q; c_d = c_q;
    r0_d = r0_q; c0_d = c0_q; r1_d = r1_q; c1_d = c1_q;
    out_valid_d = out_valid_q && !out_fire;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    ctl         = '0;
    ctl.mean    = mode_q;

    if (pix_we) begin
      if ({1'b0, in_col_q} + 11'd1 >= w_eff) begin
        in_col_d = '0;
        if ({1'b0, in_row_q} + 11'd1 >= h_eff) begin
          in_row_d  = '0;
          in_done_d = 1'b1;
        end else begin
          in_row_d = in_row_q + 10'd1;
        end
      end else begin
        in_col_d = in_col_q + 10'd1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (win_ready) begin
          ctl.clr = 1'b1;
          r0_d = (out_row_q > {8'd0, nm}) ? out_row_q - {8'd0, nm} : '0;
          c0_d = (out_col_q > {8'd0, nm}) ? out_col_q - {8'd0, nm} : '0;
          r1_d = r1_c[9:0];
          c1_d = c1_c[9:0];
          r_d  = r0_d;
          c_d  = c0_d;
          state_d = S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_CAP;
      end
      S_CAP: begin
        ctl.cap = 1'b1;
        if (c_q == c1_q) begin
          c_d = c0_q;
          if (r_q == r1_q) begin
            state_d = S_GO;
          end else begin
            r_d = r_q + 10'd1;
            state_d = S_RD;
          end
        end else begin
          c_d = c_q + 10'd1;
          state_d = S_RD;
        end
      end
      S_GO: begin
        ctl.go  = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        if (stat.done && !out_valid_q) begin
          out_valid_d = 1'b1;
          out_data_d  = {stat.blue, stat.green, stat.red};
          out_last_d  = ({1'b0, out_row_q} == h_eff - 11'd1)
                     && ({1'b0, out_col_q} == w_eff - 11'd1);
          if ({1'b0, out_col_q} + 11'd1 >= w_eff) begin
            out_col_d = '0;
            if ({1'b0, out_row_q} + 11'd1 >= h_eff) begin
              out_row_d = '0;
              in_done_d = 1'b0;
            end else begin
              out_row_d = out_row_q + 10'd1;
            end
          end else begin
            out_col_d = out_col_q + 10'd1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a config write to any mapped index restarts the frame
    if (cfg_acc && (cfg_index_i == rwmf_pkg::REG_WIDTH || cfg_index_i == rwmf_pkg::REG_HEIGHT
        || cfg_index_i == rwmf_pkg::REG_WINDOW || cfg_index_i == rwmf_pkg::REG_MODE)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      in_done_d = 1'b0;
      state_d   = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 11'd640;
      height_q    <= 11'd480;
      wsize_q     <= 3'd3;
      mode_q      <= 1'b0;
      state_q     <= S_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      in_done_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index_i)
          rwmf_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
          rwmf_pkg::REG_HEIGHT: height_q <= cfg_data_i;
          rwmf_pkg::REG_WINDOW: wsize_q  <= cfg_data_i[2:0];
          rwmf_pkg::REG_MODE:   mode_q   <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      in_done_q   <= in_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    c_q <= c_d;
    r0_q <= r0_d;
    c0_q <= c0_d;
    r1_q <= r1_d;
    c1_q <= c1_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`include "rgb_window_mean_median_filter_unit_defines.svh"

  `RWMF_ASSERT_NOW(a_in_row_bound, 1'b1, {1'b0, in_row_q} < h_eff, "input row past frame")
  `RWMF_ASSERT_NEXT(a_accept_to_check, in_acc && !cfg_acc, state_q == S_CHECK,
    "accepted word not checked")
  `RWMF_ASSERT_NEXT(a_result_loaded, state_q == S_CALC && stat.done && !out_valid_q,
    out_valid_q, "finished result not loaded")

endmodule

>>> tb/rwmf_checker.sv
// Checker for the RGB window filter: predicts each output word and compares it.
module rwmf_checker
  import rwmf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0] rgb;
    logic        last;
  } filt_word_t;

  logic [10:0] width_q, height_q;
  logic [2:0]  win_q;
  logic        mean_q;

  logic [23:0] line_mem [RING_ROWS*MAX_WIDTH];
  logic [23:0] cells [MAX_CELLS];
  int unsigned in_col, in_row, out_col, out_row;
  bit          in_done;
  filt_word_t  filtered_q [$];
  int          mismatches, matched;

  function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned line_slot(int unsigned row, int unsigned col);
    return (row % RING_ROWS) * MAX_WIDTH + (col % MAX_WIDTH);
  endfunction

  // Floored mean or median of one 8-bit channel over the gathered cells.
  function automatic logic [7:0] channel_stat(int unsigned cnt, int unsigned sh);
    int unsigned v [MAX_CELLS];
    int unsigned sum, x, j;
    sum = 0;
    for (int i = 0; i < cnt; i++) begin
      v[i] = (cells[i] >> sh) & 8'hff;
      sum += v[i];
    end
    if (mean_q) return 8'(sum / cnt);
    for (int i = 1; i < cnt; i++) begin
      x = v[i];
      j = i;
      while (j > 0 && v[j-1] > x) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = x;
    end
    if (cnt % 2) return 8'(v[cnt/2]);
    return 8'((v[cnt/2-1] + v[cnt/2]) / 2);
  endfunction

  task automatic restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    in_done = 0;
  endtask

  task automatic take_word(logic drain, logic [23:0] px);
    int unsigned w, h, nm, got, need, r0, r1, c0, c1, cnt;
    filt_word_t res;
    w  = clamp_dim(width_q, MAX_WIDTH);
    h  = clamp_dim(height_q, MAX_HEIGHT);
    nm = win_q >> 1;
    if (in_col >= w || in_row >= h) begin
      in_col = 0; in_row = 0;
    end
    if (out_col >= w || out_row >= h) begin
      out_col = 0; out_row = 0;
    end
    // a pixel that arrives while the tail drains is dropped
    if (!drain && !in_done) begin
      line_mem[line_slot(in_row, in_col)] = px;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          in_done = 1;
        end
      end
    end
    got = in_done ? w * h : in_row * w + in_col;
    r1 = (out_row + nm > h - 1) ? h - 1 : out_row + nm;
    c1 = (out_col + nm > w - 1) ? w - 1 : out_col + nm;
    need = r1 * w + c1;
    if (need >= got) return;
    r0 = out_row > nm ? out_row - nm : 0;
    c0 = out_col > nm ? out_col - nm : 0;
    cnt = 0;
    for (int unsigned r = r0; r <= r1; r++)
      for (int unsigned c = c0; c <= c1; c++)
        if (cnt < MAX_CELLS) begin
          cells[cnt] = line_mem[line_slot(r, c)];
          cnt++;
        end
    res.rgb  = {channel_stat(cnt, 16), channel_stat(cnt, 8), channel_stat(cnt, 0)};
    res.last = (out_row == h - 1 && out_col == w - 1);
    filtered_q.push_back(res);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) begin
        out_row = 0;
        in_done = 0;
      end
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 40)
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filt_word_t want;
    if (!rst_ni) begin
      width_q  = 11'd640;
      height_q = 11'd480;
      win_q    = 3'd3;
      mean_q   = 1'b0;
      restart_frame();
      filtered_q.delete();
      mismatches = 0;
      matched    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_WIDTH:  width_q  = cfg_data_i;
          REG_HEIGHT: height_q = cfg_data_i;
          REG_WINDOW: win_q    = cfg_data_i[2:0];
          REG_MODE:   mean_q   = cfg_data_i[0];
          default: ;
        endcase
        if (cfg_index_i <= REG_MODE) restart_frame();
      end
      if (s_axis_tvalid && s_axis_tready) take_word(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          report_mismatch("word with none expected", m_axis_tdata, 0);
        end else begin
          want = filtered_q.pop_front();
          matched++;
          if (m_axis_tdata[7:0] !== want.rgb[7:0])
            report_mismatch("red", m_axis_tdata[7:0], want.rgb[7:0]);
          if (m_axis_tdata[15:8] !== want.rgb[15:8])
            report_mismatch("green", m_axis_tdata[15:8], want.rgb[15:8]);
          if (m_axis_tdata[23:16] !== want.rgb[23:16])
            report_mismatch("blue", m_axis_tdata[23:16], want.rgb[23:16]);
          if (m_axis_tlast !== want.last)
            report_mismatch("tlast", m_axis_tlast, want.last);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= filtered_q.size();
    results_o    <= matched;
  end

endmodule

>>> tb/tb_rgb_window_mean_median_filter_unit.sv
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the filter.
module tb_rgb_window_mean_median_filter_unit;
  import rwmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_WORDS = 1850;
  localparam int SETTLE       = 600;    // settle time after the last predicted word
  localparam int STALL_LEN    = 3000;   // long receiver hold-off
  localparam int WD_LIMIT     = 20000;  // cycles without any handshake
  localparam logic [2:0] REG_UNUSED = 3'd5;  // index outside the register map

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;     // pixel_red, pixel_green, pixel_blue
  logic        s_axis_tuser = 1'b0;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // out_red, out_green, out_blue
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;

  int fail_count, pending, results;
  int words_sent, frames_sent, idle_cycles;
  bit hold_req, hold_done;

  // shadow of the registers, used only to shape frames
  logic [10:0] width_r, height_r;
  logic [2:0]  win_r;

  always #5 clk_i = ~clk_i;

  rgb_window_mean_median_filter_unit i_dut (.*);

  rwmf_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  // Gap length: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Receiver side: random tready, plus one long hold-off on request.
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (STALL_LEN) @(posedge clk_i);
        hold_done = 1;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (gap - 1) @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog: any handshake resets the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WD_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(logic drain, logic [23:0] px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= drain;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (words_sent > 800 && !hold_req) hold_req = 1;
  endtask

  // Wait until every predicted word is out and the block has settled.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_WIDTH:  width_r  = val;
      REG_HEIGHT: height_r = val;
      REG_WINDOW: win_r    = val[2:0];
      default: ;
    endcase
  endtask

  function automatic logic [23:0] rand_pixel();
    logic [23:0] px;
    px = 24'($urandom);
    for (int ch = 0; ch < 3; ch++)
      case ($urandom_range(7))
        0: px[ch*8 +: 8] = 8'h00;
        1: px[ch*8 +: 8] = 8'hff;
        default: ;
      endcase
    return px;
  endfunction

  // One frame: npix pixels (a stray drain now and then), then, if flush is set,
  // enough drains to flush the tail, with the odd pixel mixed in while draining.
  task automatic run_frame(int npix, bit flush);
    int w, nm;
    w  = (width_r == 0) ? 1 : (width_r > MAX_WIDTH ? MAX_WIDTH : width_r);
    nm = win_r >> 1;
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(99) < 6) send_word(1'b1, 24'($urandom));
      send_word(1'b0, rand_pixel());
    end
    if (flush)
      for (int i = 0; i < (nm + 1) * w + 2; i++)
        send_word($urandom_range(99) >= 5, 24'($urandom));
    frames_sent++;
  endtask

  initial begin
    int w, h, npix;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    width_r = 640; height_r = 480; win_r = 3;

    // Directed: 3x2 frame with extreme pixels, both modes, then 1x1 corners.
    write_reg(REG_WIDTH, 11'd3);
    write_reg(REG_HEIGHT, 11'd2);
    write_reg(REG_WINDOW, 11'd3);
    write_reg(REG_MODE, 11'd0);
    for (int m = 0; m < 2; m++) begin
      if (m == 1) begin
        wait_idle();
        write_reg(REG_MODE, 11'd1);
      end
      send_word(1'b0, 24'h000000);
      send_word(1'b0, 24'hffffff);
      send_word(1'b0, 24'h00ff00);
      send_word(1'b1, 24'hffffff);  // drain while frame incomplete
      send_word(1'b0, 24'hff00ff);
      send_word(1'b0, 24'h5a5a5a);
      send_word(1'b0, 24'ha5a5a5);
      send_word(1'b0, 24'h123456);  // pixel during drain is dropped
      send_word(1'b1, 24'h0);
      send_word(1'b1, 24'h0);
      send_word(1'b1, 24'h0);       // last drain yields the frame's last output
    end
    wait_idle();
    write_reg(REG_UNUSED, 11'h7ff); // index beyond the map is ignored
    write_reg(REG_WIDTH, 11'd0);    // acts as 1
    write_reg(REG_HEIGHT, 11'd0);
    write_reg(REG_WINDOW, 11'd0);
    send_word(1'b0, 24'hffffff);
    send_word(1'b1, 24'h0);
    // Oversized width and height with the largest window, aborted part way.
    wait_idle();
    write_reg(REG_WIDTH, 11'h7ff);
    write_reg(REG_HEIGHT, 11'h7ff);
    write_reg(REG_WINDOW, 11'd7);
    run_frame(20, 0);

    // Random frames with random settings.
    while (words_sent < TARGET_WORDS + 40) begin
      wait_idle();
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0:       write_reg(REG_WIDTH, 11'd0);
          1:       write_reg(REG_WIDTH, 11'($urandom_range(2047, 13)));
          2:       write_reg(REG_WIDTH, 11'd1024);
          default: write_reg(REG_WIDTH, 11'($urandom_range(12, 1)));
        endcase
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0:       write_reg(REG_HEIGHT, 11'd0);
          1:       write_reg(REG_HEIGHT, 11'($urandom_range(2047, 9)));
          default: write_reg(REG_HEIGHT, 11'($urandom_range(8, 1)));
        endcase
      end
      if ($urandom_range(2)) write_reg(REG_WINDOW, 11'($urandom_range(7)));
      if ($urandom_range(1)) write_reg(REG_MODE, 11'($urandom_range(1)));
      w = (width_r == 0) ? 1 : (width_r > MAX_WIDTH ? MAX_WIDTH : width_r);
      h = (height_r == 0) ? 1 : (height_r > MAX_HEIGHT ? MAX_HEIGHT : height_r);
      npix = w * h;
      if (npix > 120) begin
        run_frame($urandom_range(40, 5), 0);   // big frame: abort part way
      end else begin
        repeat ($urandom_range(2, 1)) run_frame(npix, 1);
      end
    end

    wait_idle();
    $display("covered %0d input words over %0d frames, %0d output words checked",
             words_sent, frames_sent, results);
    $display("all registers swept incl. zero and oversized sizes, both modes");
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
